// ===== hdl/cst_pkg.sv =====
// Shared types and constants for the connection slot table.
`default_nettype none
package cst_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 4;

  // Fixed field widths
  localparam int OPW    = 2;
  localparam int IDW    = 8;
  localparam int TSW    = 32;
  localparam int QSW    = 2;
  localparam int OCNTW  = 3;

  // Request operation codes
  typedef enum logic [OPW-1:0] {
    OP_CONNECT    = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_QUERY      = 2'd2,
    OP_NOP        = 2'd3
  } cst_op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } cst_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_op;
    logic last;
    logic out_free;
  } cst_stat_t;

endpackage
`default_nettype wire

// ===== hdl/connection_slot_table_oldest_evict.sv =====
// Top level of the connection slot table with oldest-entry eviction.
//
// Usage: requests arrive on the in_ channel (valid/ready); each request gives
// exactly one result on the out_ channel (valid/ready). Opcode connect places
// a client in the first free slot, evicting the oldest slot when the table is
// full; disconnect frees the first slot whose id matches; query reads a slot.
// A connect or disconnect is captured at the accepting edge, then scans one slot
// per cycle through the single read port of the slot store and then commits; a
// query or no-op goes from capture straight to commit. A new request can be taken
// in the cycle after the previous commit, and none while a request is scanned or
// waits to commit.
// Reset (rst_n low, synchronous) frees every slot, clears ids and stamps to
// zero and empties the result register.
// When the receiver stalls, the result register holds its value; the next
// request may still be taken and scanned, and waits at commit until the
// result register has been taken.
`default_nettype none
module connection_slot_table_oldest_evict #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [cst_pkg::OPW-1:0]    in_opcode,
  input  wire logic [cst_pkg::IDW-1:0]    in_client_id,
  input  wire logic [cst_pkg::TSW-1:0]    in_now_ms,
  input  wire logic [cst_pkg::QSW-1:0]    in_query_slot,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_evicted,
  output logic [cst_pkg::IDW-1:0]         out_evicted_id,
  output logic [cst_pkg::QSW-1:0]         out_slot_index,
  output logic                            out_slot_hit,
  output logic [cst_pkg::OCNTW-1:0]       out_connected_count,
  output logic                            out_slot_connected,
  output logic [cst_pkg::IDW-1:0]         out_slot_client_id
);
  import cst_pkg::*;

  cst_cmd_t  cmd;
  cst_stat_t stat;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_client_id        (in_client_id),
    .in_now_ms           (in_now_ms),
    .in_query_slot       (in_query_slot),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_evicted         (out_evicted),
    .out_evicted_id      (out_evicted_id),
    .out_slot_index      (out_slot_index),
    .out_slot_hit        (out_slot_hit),
    .out_connected_count (out_connected_count),
    .out_slot_connected  (out_slot_connected),
    .out_slot_client_id  (out_slot_client_id)
  );

endmodule
`default_nettype wire

// ===== hdl/cst_ctrl.sv =====
// Sequencer for the connection slot table: accept, scan the slots, commit.
`default_nettype none
module cst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cst_pkg::cst_stat_t stat,
  output cst_pkg::cst_cmd_t      cmd
);
  import cst_pkg::*;

  cst_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.scan_op ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stat.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive the commands
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Check the sequencing
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE)
    else $error("load outside idle");
  a_commit_back: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == ST_IDLE)
    else $error("commit did not return to idle");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.commit}))
    else $error("more than one command");

endmodule
`default_nettype wire

// ===== hdl/cst_dp.sv =====
// Datapath for the connection slot table: slot store, scan registers, result register.
`default_nettype none
module cst_dp #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cst_pkg::cst_cmd_t          cmd,
  output cst_pkg::cst_stat_t              stat,
  input  wire logic [cst_pkg::OPW-1:0]    in_opcode,
  input  wire logic [cst_pkg::IDW-1:0]    in_client_id,
  input  wire logic [cst_pkg::TSW-1:0]    in_now_ms,
  input  wire logic [cst_pkg::QSW-1:0]    in_query_slot,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_evicted,
  output logic [cst_pkg::IDW-1:0]         out_evicted_id,
  output logic [cst_pkg::QSW-1:0]         out_slot_index,
  output logic                            out_slot_hit,
  output logic [cst_pkg::OCNTW-1:0]       out_connected_count,
  output logic                            out_slot_connected,
  output logic [cst_pkg::IDW-1:0]         out_slot_client_id
);
  import cst_pkg::*;

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0]   LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(SLOTS);
  localparam logic [IDW-1:0]  FREE_ID  = IDW'(SLOTS);

  // Slot store
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [IDW-1:0]   owner_r [SLOTS];
  logic [IDW-1:0]   owner_nxt [SLOTS];
  logic [TSW-1:0]   stamp_r [SLOTS];
  logic [TSW-1:0]   stamp_nxt [SLOTS];
  logic [CNTW-1:0]  count_r, count_nxt;

  // Request and scan registers
  cst_op_t          op_r, op_nxt;
  logic [IDW-1:0]   cid_r, cid_nxt;
  logic [TSW-1:0]   now_r, now_nxt;
  logic [QSW-1:0]   q_r, q_nxt;
  logic             q_ok_r, q_ok_nxt;
  logic             full_r, full_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [IW-1:0]    sel_r, sel_nxt;
  logic             found_r, found_nxt;
  logic             sel_used_r, sel_used_nxt;
  logic [TSW-1:0]   best_r, best_nxt;
  logic [IDW-1:0]   evid_r, evid_nxt;

  // Result register
  logic             ov_r, ov_nxt;
  logic             ev_r, ev_nxt;
  logic [IDW-1:0]   evid_o_r, evid_o_nxt;
  logic [QSW-1:0]   idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic [CNTW-1:0]  ocnt_r, ocnt_nxt;
  logic             sc_r, sc_nxt;
  logic [IDW-1:0]   sid_r, sid_nxt;

  // Single read port at the scan pointer
  logic             rd_used;
  logic [IDW-1:0]   rd_owner;
  logic [TSW-1:0]   rd_age;
  logic             in_q_ok;
  cst_op_t          in_op;

  assign rd_used  = used_r[ptr_r];
  assign rd_owner = owner_r[ptr_r];
  assign rd_age   = now_r - stamp_r[ptr_r];
  assign in_q_ok  = (32'(in_query_slot) < SLOTS);
  assign in_op    = cst_op_t'(in_opcode);

  assign stat.scan_op  = (in_op == OP_CONNECT) || (in_op == OP_DISCONNECT);
  assign stat.last     = (ptr_r == LAST_IDX);
  assign stat.out_free = !ov_r || out_ready;

  // Capture the request and walk the slots
  always_comb begin
    op_nxt       = op_r;
    cid_nxt      = cid_r;
    now_nxt      = now_r;
    q_nxt        = q_r;
    q_ok_nxt     = q_ok_r;
    full_nxt     = full_r;
    ptr_nxt      = ptr_r;
    sel_nxt      = sel_r;
    found_nxt    = found_r;
    sel_used_nxt = sel_used_r;
    best_nxt     = best_r;
    evid_nxt     = evid_r;
    if (cmd.load) begin
      op_nxt       = in_op;
      cid_nxt      = in_client_id;
      now_nxt      = in_now_ms;
      q_nxt        = in_query_slot;
      q_ok_nxt     = in_q_ok;
      full_nxt     = (count_r == FULL_CNT);
      ptr_nxt      = ((in_op == OP_QUERY) && in_q_ok) ? IW'(in_query_slot) : '0;
      sel_nxt      = '0;
      found_nxt    = 1'b0;
      sel_used_nxt = 1'b0;
      best_nxt     = '0;
      evid_nxt     = '0;
    end else if (cmd.step) begin
      ptr_nxt = stat.last ? '0 : ptr_r + 1'b1;
      unique case (op_r)
        OP_CONNECT: begin
          if (full_r) begin
            // Oldest wins, later index on a tie
            if (rd_age >= best_r) begin
              best_nxt  = rd_age;
              sel_nxt   = ptr_r;
              evid_nxt  = rd_owner;
              found_nxt = 1'b1;
            end
          end else if (!found_r && !rd_used) begin
            sel_nxt   = ptr_r;
            found_nxt = 1'b1;
          end
        end
        OP_DISCONNECT: begin
          if (!found_r && (rd_owner == cid_r)) begin
            sel_nxt      = ptr_r;
            sel_used_nxt = rd_used;
            found_nxt    = 1'b1;
          end
        end
        OP_QUERY, OP_NOP: begin
          found_nxt = found_r;
        end
        default: found_nxt = found_r;
      endcase
    end
  end

  // Build the result and update the store
  always_comb begin
    used_nxt   = used_r;
    owner_nxt  = owner_r;
    stamp_nxt  = stamp_r;
    count_nxt  = count_r;
    ov_nxt     = ov_r && !out_ready;
    ev_nxt     = ev_r;
    evid_o_nxt = evid_o_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    ocnt_nxt   = ocnt_r;
    sc_nxt     = sc_r;
    sid_nxt    = sid_r;
    if (cmd.commit) begin
      ov_nxt     = 1'b1;
      ev_nxt     = 1'b0;
      evid_o_nxt = '0;
      idx_nxt    = '0;
      hit_nxt    = 1'b0;
      sc_nxt     = rd_used;
      sid_nxt    = rd_owner;
      unique case (op_r)
        OP_CONNECT: begin
          // An eviction frees the victim, which the client then takes
          ev_nxt           = full_r;
          evid_o_nxt       = evid_r;
          idx_nxt          = QSW'(sel_r);
          hit_nxt          = 1'b1;
          sc_nxt           = 1'b1;
          sid_nxt          = cid_r;
          used_nxt[sel_r]  = 1'b1;
          owner_nxt[sel_r] = cid_r;
          stamp_nxt[sel_r] = now_r;
          if (!full_r) begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DISCONNECT: begin
          if (found_r) begin
            idx_nxt          = QSW'(sel_r);
            hit_nxt          = 1'b1;
            sc_nxt           = 1'b0;
            sid_nxt          = FREE_ID;
            used_nxt[sel_r]  = 1'b0;
            owner_nxt[sel_r] = FREE_ID;
            stamp_nxt[sel_r] = now_r;
            if (sel_used_r) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        OP_QUERY: begin
          idx_nxt = q_r;
          if (!q_ok_r) begin
            sc_nxt  = 1'b0;
            sid_nxt = '0;
          end
        end
        OP_NOP: begin
          idx_nxt = '0;
        end
        default: idx_nxt = '0;
      endcase
      ocnt_nxt = count_nxt;
    end
  end

  // Hold the store and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      owner_r <= '{default: '0};
      stamp_r <= '{default: '0};
      count_r <= '0;
      ov_r    <= 1'b0;
      ptr_r   <= '0;
    end else begin
      used_r  <= used_nxt;
      owner_r <= owner_nxt;
      stamp_r <= stamp_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Hold the payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cid_r      <= cid_nxt;
    now_r      <= now_nxt;
    q_r        <= q_nxt;
    q_ok_r     <= q_ok_nxt;
    full_r     <= full_nxt;
    sel_r      <= sel_nxt;
    found_r    <= found_nxt;
    sel_used_r <= sel_used_nxt;
    best_r     <= best_nxt;
    evid_r     <= evid_nxt;
    ev_r       <= ev_nxt;
    evid_o_r   <= evid_o_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    ocnt_r     <= ocnt_nxt;
    sc_r       <= sc_nxt;
    sid_r      <= sid_nxt;
  end

  assign out_valid           = ov_r;
  assign out_evicted         = ev_r;
  assign out_evicted_id      = evid_o_r;
  assign out_slot_index      = idx_r;
  assign out_slot_hit        = hit_r;
  assign out_connected_count = OCNTW'(ocnt_r);
  assign out_slot_connected  = sc_r;
  assign out_slot_client_id  = sid_r;

  // Check the store bookkeeping
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(used_r)) == 32'(count_r))
    else $error("connected count out of step with slot flags");
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (op_r == OP_CONNECT) && full_r |=> out_evicted && (count_r == FULL_CNT))
    else $error("eviction without a full table");
  a_connect_placed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (op_r == OP_CONNECT) |=> out_valid && out_slot_hit && out_slot_connected)
    else $error("connect did not place the client");

endmodule
`default_nettype wire

// ===== tb/slot_table_checker.sv =====
// Checker for the connection slot table: predicts each result and compares it.
`timescale 1ns / 1ps
module slot_table_checker #(
  parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [cst_pkg::OPW-1:0]   in_opcode,
  input  logic [cst_pkg::IDW-1:0]   in_client_id,
  input  logic [cst_pkg::TSW-1:0]   in_now_ms,
  input  logic [cst_pkg::QSW-1:0]   in_query_slot,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_evicted,
  input  logic [cst_pkg::IDW-1:0]   out_evicted_id,
  input  logic [cst_pkg::QSW-1:0]   out_slot_index,
  input  logic                      out_slot_hit,
  input  logic [cst_pkg::OCNTW-1:0] out_connected_count,
  input  logic                      out_slot_connected,
  input  logic [cst_pkg::IDW-1:0]   out_slot_client_id,
  output int                        fail_count,
  output int                        pending_count
);
  import cst_pkg::*;

  typedef struct packed {
    logic             evicted;
    logic [IDW-1:0]   evicted_id;
    logic [QSW-1:0]   slot_index;
    logic             slot_hit;
    logic [OCNTW-1:0] connected_count;
    logic             slot_connected;
    logic [IDW-1:0]   slot_client_id;
  } slot_result_t;

  // Shadow copy of the slot table
  logic           shadow_busy  [SLOTS];
  logic [IDW-1:0] shadow_owner [SLOTS];
  logic [TSW-1:0] shadow_stamp [SLOTS];

  slot_result_t expected_results[$];

  // Free a slot: owner takes the table size as sentinel, stamp takes now
  task automatic free_slot(input int i, input logic [TSW-1:0] now);
    shadow_busy[i]  = 1'b0;
    shadow_owner[i] = IDW'(SLOTS);
    shadow_stamp[i] = now;
  endtask

  // Apply one request to the shadow table and work out its result
  task automatic apply_request(input cst_op_t op, input logic [IDW-1:0] id,
                               input logic [TSW-1:0] now, input logic [QSW-1:0] q,
                               output slot_result_t r);
    logic           full;
    logic           done;
    logic [TSW-1:0] age;
    logic [TSW-1:0] oldest;
    int             victim;
    int             idx;
    int             cnt;
    r   = '0;
    idx = 0;
    case (op)
      OP_CONNECT: begin
        full = 1'b1;
        for (int i = 0; i < SLOTS; i++)
          if (!shadow_busy[i]) full = 1'b0;
        // Evict the oldest slot; on equal ages the later index wins
        if (full) begin
          oldest = '0;
          victim = 0;
          for (int i = 0; i < SLOTS; i++) begin
            age = now - shadow_stamp[i];
            if (age >= oldest) begin
              oldest = age;
              victim = i;
            end
          end
          r.evicted    = 1'b1;
          r.evicted_id = shadow_owner[victim];
          free_slot(victim, now);
        end
        done = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !shadow_busy[i]) begin
            shadow_busy[i]  = 1'b1;
            shadow_owner[i] = id;
            shadow_stamp[i] = now;
            idx             = i;
            r.slot_hit      = 1'b1;
            done            = 1'b1;
          end
        end
      end
      OP_DISCONNECT: begin
        // First owner match is freed, connected or not
        done = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && shadow_owner[i] == id) begin
            free_slot(i, now);
            idx        = i;
            r.slot_hit = 1'b1;
            done       = 1'b1;
          end
        end
      end
      OP_QUERY: idx = int'(q);
      default:  idx = 0;
    endcase
    if (idx < SLOTS) begin
      r.slot_connected = shadow_busy[idx];
      r.slot_client_id = shadow_owner[idx];
    end
    cnt = 0;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_busy[i]) cnt++;
    r.slot_index      = QSW'(idx);
    r.connected_count = OCNTW'(cnt);
  endtask

  // Compare accepted results first, then predict for the accepted request
  always @(posedge clk) begin : watch
    slot_result_t got;
    slot_result_t want;
    logic         bad;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_busy[i]  = 1'b0;
        shadow_owner[i] = '0;
        shadow_stamp[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_evicted, out_evicted_id, out_slot_index, out_slot_hit,
                out_connected_count, out_slot_connected, out_slot_client_id};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request outstanding: idx=%0d id=%h",
                     $realtime, got.slot_index, got.slot_client_id);
        end else begin
          want = expected_results.pop_front();
          bad  = (got.evicted         !== want.evicted)         ||
                 (got.evicted_id      !== want.evicted_id)      ||
                 (got.slot_index      !== want.slot_index)      ||
                 (got.slot_hit        !== want.slot_hit)        ||
                 (got.connected_count !== want.connected_count) ||
                 (got.slot_connected  !== want.slot_connected)  ||
                 (got.slot_client_id  !== want.slot_client_id);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp ev=%0d evid=%h idx=%0d hit=%0d ", $realtime,
                       want.evicted, want.evicted_id, want.slot_index, want.slot_hit,
                       "cnt=%0d conn=%0d id=%h ",
                       want.connected_count, want.slot_connected, want.slot_client_id,
                       "got ev=%0d evid=%h idx=%0d hit=%0d ",
                       got.evicted, got.evicted_id, got.slot_index, got.slot_hit,
                       "cnt=%0d conn=%0d id=%h",
                       got.connected_count, got.slot_connected, got.slot_client_id);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(cst_op_t'(in_opcode), in_client_id, in_now_ms, in_query_slot, want);
        expected_results.push_back(want);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the connection slot table: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
  import cst_pkg::*;

  localparam int SLOTS    = SLOTS_DEF;
  localparam int WATCHDOG = 2000;
  localparam int GAP_CAP  = 40;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  cst_op_t          in_opcode;
  logic [IDW-1:0]   in_client_id;
  logic [TSW-1:0]   in_now_ms;
  logic [QSW-1:0]   in_query_slot;
  logic             out_valid;
  logic             out_ready;
  logic             out_evicted;
  logic [IDW-1:0]   out_evicted_id;
  logic [QSW-1:0]   out_slot_index;
  logic             out_slot_hit;
  logic [OCNTW-1:0] out_connected_count;
  logic             out_slot_connected;
  logic [IDW-1:0]   out_slot_client_id;

  int fail_count;
  int pending_count;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int quiet_cycles;
  logic [TSW-1:0] clock_ms;

  connection_slot_table_oldest_evict #(.SLOTS(SLOTS)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_client_id        (in_client_id),
    .in_now_ms           (in_now_ms),
    .in_query_slot       (in_query_slot),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_evicted         (out_evicted),
    .out_evicted_id      (out_evicted_id),
    .out_slot_index      (out_slot_index),
    .out_slot_hit        (out_slot_hit),
    .out_connected_count (out_connected_count),
    .out_slot_connected  (out_slot_connected),
    .out_slot_client_id  (out_slot_client_id)
  );

  slot_table_checker #(.SLOTS(SLOTS)) u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_client_id        (in_client_id),
    .in_now_ms           (in_now_ms),
    .in_query_slot       (in_query_slot),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_evicted         (out_evicted),
    .out_evicted_id      (out_evicted_id),
    .out_slot_index      (out_slot_index),
    .out_slot_hit        (out_slot_hit),
    .out_connected_count (out_connected_count),
    .out_slot_connected  (out_slot_connected),
    .out_slot_client_id  (out_slot_client_id),
    .fail_count          (fail_count),
    .pending_count       (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("connection_slot_table_oldest_evict regression: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, or a long hold-off once when asked for
  initial begin : result_side
    bit hold_taken;
    out_ready  = 1'b0;
    hold_taken = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0 && !hold_taken) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_taken = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input cst_op_t op, input logic [IDW-1:0] id,
                              input logic [TSW-1:0] now, input logic [QSW-1:0] q);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_client_id  <= id;
    in_now_ms     <= now;
    in_query_slot <= q;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random traffic: ids mostly from a small pool so that disconnects match
  task automatic random_traffic(input int count);
    int             pick;
    cst_op_t        op;
    logic [IDW-1:0] id;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      op = (pick < 35) ? OP_CONNECT : (pick < 65) ? OP_DISCONNECT :
           (pick < 90) ? OP_QUERY : OP_NOP;
      pick = $urandom_range(99);
      if (pick < 65)      id = IDW'($urandom_range(5)) ^ ($urandom_range(1) ? 8'hF0 : 8'h00);
      else if (pick < 80) id = $urandom_range(1) ? IDW'(SLOTS) : '0;
      else                id = IDW'($urandom_range(255));
      // Advance time mostly forward, with repeats for ties and wild jumps
      pick = $urandom_range(99);
      if (pick < 65)      clock_ms = clock_ms + $urandom_range(1, 50);
      else if (pick < 80) clock_ms = clock_ms;
      else if (pick < 92) clock_ms = $urandom;
      else                clock_ms = clock_ms + $urandom_range(1000, 100000);
      send_request(op, id, clock_ms, QSW'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_NOP;
    in_client_id  = '0;
    in_now_ms     = '0;
    in_query_slot = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    clock_ms      = 32'd10000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: free slot id after reset, query, no-op and filling up
    send_request(OP_DISCONNECT, 8'h00, 32'd50, 2'd0);
    send_request(OP_QUERY, 8'h00, 32'd0, 2'd3);
    send_request(OP_NOP, 8'hAA, 32'hFFFF_FFFF, 2'd3);
    send_request(OP_CONNECT, 8'h11, 32'd100, 2'd0);
    send_request(OP_CONNECT, 8'hFF, 32'd200, 2'd1);
    send_request(OP_CONNECT, 8'h00, 32'd300, 2'd2);
    send_request(OP_CONNECT, 8'h80, 32'd400, 2'd3);
    send_request(OP_QUERY, 8'h00, 32'd400, 2'd1);
    send_request(OP_QUERY, 8'hFF, 32'd400, 2'd2);
    // Full table: evict the oldest, then miss, free and match the sentinel id
    send_request(OP_CONNECT, 8'h5A, 32'hFFFF_FFFF, 2'd0);
    send_request(OP_DISCONNECT, 8'h99, 32'd500, 2'd0);
    send_request(OP_DISCONNECT, 8'hFF, 32'd600, 2'd0);
    send_request(OP_DISCONNECT, 8'(SLOTS), 32'd700, 2'd0);
    send_request(OP_CONNECT, 8'h01, 32'h0000_0010, 2'd0);
    // Ages that wrap past zero
    send_request(OP_CONNECT, 8'h02, 32'h0000_0020, 2'd0);
    // Equal ages: the later index is evicted
    send_request(OP_DISCONNECT, 8'h5A, 32'd9000, 2'd0);
    send_request(OP_DISCONNECT, 8'h01, 32'd9000, 2'd0);
    send_request(OP_DISCONNECT, 8'h02, 32'd9000, 2'd0);
    send_request(OP_DISCONNECT, 8'h80, 32'd9000, 2'd0);
    send_request(OP_CONNECT, 8'hC3, 32'd9000, 2'd0);
    send_request(OP_CONNECT, 8'h3C, 32'd9000, 2'd0);
    send_request(OP_CONNECT, 8'h0F, 32'd9000, 2'd0);
    send_request(OP_CONNECT, 8'hF0, 32'd9000, 2'd0);
    send_request(OP_CONNECT, 8'h77, 32'd9000, 2'd0);
    send_request(OP_QUERY, 8'h55, 32'd9000, 2'd0);

    // Back-pressure: hold the result side while requests keep coming
    hold_cycles = 80;
    random_traffic(170);

    send_idle_pct = 79;
    random_traffic(170);

    send_idle_pct = 0;
    stall_pct     = 79;
    random_traffic(170);

    send_idle_pct = 21;
    stall_pct     = 21;
    random_traffic(170);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then keep watching for stray results before the verdict
    while (pending_count != 0) @(negedge clk);
    repeat (4 * (SLOTS + 3)) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("connection_slot_table_oldest_evict regression: pass");
    end else begin
      $display("connection_slot_table_oldest_evict regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cst_pkg.sv
hdl/cst_ctrl.sv
hdl/cst_dp.sv
hdl/connection_slot_table_oldest_evict.sv
tb/slot_table_checker.sv
tb/tb.sv
